[src/blwo_pkg.sv]
// Shared types, constants and codes of the band-limited wavetable oscillator.
`timescale 1ns / 1ps
package blwo_pkg;

  localparam int TABLE_LENGTH_DEF = 1024;
  localparam int OCTAVE_COUNT_DEF = 10;

  // Lowest pitch of octave zero, in sixteenths of a hertz (20 Hz).
  localparam int BASE_LOW = 320;
  // The lowest pitch of octave zero is five times two to this power.
  localparam int BASE_LOW_SHIFT = 6;
  localparam int PITCH_W = 19;
  localparam int RATE_W = 18;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 19;
  localparam int PHASE_FRAC_W = 16;
  localparam int OCT_FRAC_W = 12;

  localparam logic [PITCH_W-1:0] PITCH_RESET = 19'd7040;
  localparam logic [RATE_W-1:0] RATE_RESET = 18'd48000;

  // Reciprocal of ten in Q0.19, exact for magnitudes up to a full-scale sample.
  localparam logic [15:0] RECIP_TEN = 16'd52429;
  localparam int RECIP_SHIFT = 19;

  // Reciprocal of five in Q0.18, exact for every octave fraction numerator.
  localparam logic [15:0] RECIP_FIVE = 16'd52429;
  localparam int RECIP_FIVE_SHIFT = 18;

  localparam logic [CFG_IDX_W-1:0] CFG_PITCH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE = 2'd1;

  // One classified command handed from the front to the back.
  typedef struct packed {
    logic        tick;
    logic        wr_ok;
    logic [3:0]  oct;
    logic [9:0]  idx;
    logic [15:0] val;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIVW, ST_DIVI, ST_RA0, ST_RB0, ST_RA1, ST_RB1, ST_CAP,
    ST_MLO, ST_MHI, ST_MIX, ST_SCL, ST_OUT
  } state_e;

endpackage

[src/blwo_div.sv]
// Restoring divider that resolves one quotient bit per cycle.
`timescale 1ns / 1ps
module blwo_div #(
  parameter int NW = 42,
  parameter int DW = 21
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          busy_o,
  output logic          done_o,
  output logic [NW-1:0] quo_o
);
  localparam int CW = $clog2(NW + 1);

  logic [DW:0]   rem_q, rem_d;
  logic [NW-1:0] quo_q, quo_d;
  logic [DW-1:0] den_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;
  logic [DW+1:0] trial;

  // One shift and trial subtraction per cycle.
  always_comb begin
    trial = {rem_q, quo_q[NW-1]};
    rem_d = rem_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = '0;
      quo_d = num_i;
      cnt_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {2'b00, den_q}) begin
        rem_d = (DW+1)'(trial - {2'b00, den_q});
        quo_d = {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_d = trial[DW:0];
        quo_d = {quo_q[NW-2:0], 1'b0};
      end
      cnt_d = CW'(cnt_q + 1'b1);
      if (cnt_q == CW'(NW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o = quo_q;
endmodule

[src/blwo_front.sv]
// Front end: accepts items, classifies them and queues them for the back end.
`timescale 1ns / 1ps
module blwo_front
  import blwo_pkg::*;
#(
  parameter int TABLE_LENGTH = TABLE_LENGTH_DEF,
  parameter int OCTAVE_COUNT = OCTAVE_COUNT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  output logic        full_o,
  input  logic        mode_i,
  input  logic [3:0]  octave_select_i,
  input  logic [9:0]  entry_index_i,
  input  logic [15:0] entry_value_i,
  output logic        cmd_valid_o,
  output cmd_t        cmd_o,
  input  logic        cmd_pop_i
);
  cmd_t       slot_q [2];
  cmd_t       cmd_in;
  logic [1:0] cnt_q;
  logic       wp_q, rp_q;
  logic       do_push, do_pop;

  // Classify: ticks, and writes that land inside the tables.
  always_comb begin
    cmd_in.tick = mode_i;
    cmd_in.wr_ok = ({28'd0, octave_select_i} < 32'(OCTAVE_COUNT)) &&
                   ({22'd0, entry_index_i} < 32'(TABLE_LENGTH));
    cmd_in.oct = octave_select_i;
    cmd_in.idx = entry_index_i;
    cmd_in.val = entry_value_i;
  end

  assign full_o = (cnt_q == 2'd2);
  assign do_push = push_i && !full_o;
  assign do_pop = cmd_pop_i && (cnt_q != 2'd0);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o = slot_q[rp_q];

  // Two-entry command queue.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wp_q <= 1'b0;
      rp_q <= 1'b0;
    end else begin
      if (do_push) begin
        wp_q <= ~wp_q;
      end
      if (do_pop) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= 2'(cnt_q + {1'b0, do_push} - {1'b0, do_pop});
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wp_q] <= cmd_in;
    end
  end
endmodule

[src/blwo_back.sv]
// Back end: table memory, tick sequencer, arithmetic and result queue.
`timescale 1ns / 1ps
module blwo_back
  import blwo_pkg::*;
#(
  parameter int TABLE_LENGTH = TABLE_LENGTH_DEF,
  parameter int OCTAVE_COUNT = OCTAVE_COUNT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_valid_i,
  input  cmd_t                  cmd_i,
  output logic                  cmd_pop_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  empty_o,
  input  logic                  pop_i,
  output logic signed [12:0]    sample_out_o
);
  localparam int IW = $clog2(TABLE_LENGTH);
  localparam int OW = $clog2(OCTAVE_COUNT);
  localparam int PW = IW + PHASE_FRAC_W;
  localparam int NW = PITCH_W + IW + OCT_FRAC_W;
  localparam int DW = 21;
  localparam int DEPTH = OCTAVE_COUNT * TABLE_LENGTH;
  localparam logic [OW-1:0] TOP = OW'(OCTAVE_COUNT - 1);

  state_e state_q, state_d;

  logic [PITCH_W-1:0] pitch_q;
  logic [RATE_W-1:0]  rate_q;
  logic [PW-1:0]      phase_q;

  logic [OW-1:0]  k_q, kup_q, k_c;
  logic [IW-1:0]  idx_q;
  logic [15:0]    frac_q;
  logic [11:0]    w_q;
  logic [14:0]    y_c, y_q;
  logic [30:0]    w_prod;
  logic [PW-1:0]  inc_q;
  logic signed [15:0] a0_q, b0_q, a1_q, b1_q;
  logic signed [16:0] lo_q, hi_q, mix_q;
  logic [32:0]    prod_q;
  logic           neg_q;

  logic           div_start, div_busy, div_done;
  logic [NW-1:0]  div_num, div_quo, wnum_c;
  logic [DW-1:0]  div_den, low_c;

  logic [15:0]    mem_q [DEPTH];
  logic [15:0]    rdata_q;
  logic [OW+IW-1:0] rd_addr, wr_addr;
  logic           mem_we;

  logic signed [16:0] d_lo, d_hi;
  logic signed [33:0] p_lo, p_hi;
  logic signed [17:0] d_mix;
  logic signed [30:0] p_mix;
  logic [16:0]    mag;
  logic [12:0]    q_mag;
  logic signed [12:0] q_out;

  logic signed [12:0] res_q [2];
  logic [1:0]     ocnt_q;
  logic           owp_q, orp_q, out_push, out_pop, out_full;

  // Configuration registers; writes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pitch_q <= PITCH_RESET;
      rate_q <= RATE_RESET;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_PITCH) begin
        pitch_q <= cfg_data_i;
      end else if (cfg_index_i == CFG_RATE) begin
        rate_q <= cfg_data_i[RATE_W-1:0];
      end
    end
  end

  // Octave position: highest octave whose lowest pitch the frequency reaches.
  // The fraction divides by five times a power of two: a shift here, then a
  // multiplication by the reciprocal of five in the next step.
  always_comb begin
    k_c = '0;
    for (int i = 1; i < OCTAVE_COUNT; i++) begin
      if ({2'b00, pitch_q} >= (DW'(BASE_LOW) << i)) begin
        k_c = OW'(i);
      end
    end
    low_c = DW'(BASE_LOW) << k_c;
    if ((k_c != TOP) && ({2'b00, pitch_q} > low_c)) begin
      wnum_c = NW'({2'b00, pitch_q} - low_c) << OCT_FRAC_W;
    end else begin
      wnum_c = '0;
    end
    y_c = 15'(wnum_c >> (BASE_LOW_SHIFT + int'(k_c)));
  end

  assign w_prod = 31'(y_q) * 31'(RECIP_FIVE);

  // Table memory: one write port, one registered read port.
  assign wr_addr = {cmd_i.oct[OW-1:0], IW'({{IW{1'b0}}, cmd_i.idx})};
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= cmd_i.val;
    end
    rdata_q <= mem_q[rd_addr];
  end

  blwo_div #(.NW(NW), .DW(DW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Datapath arithmetic, one multiplication per step.
  assign d_lo = 17'(b0_q) - 17'(a0_q);
  assign d_hi = 17'(b1_q) - 17'(a1_q);
  assign p_lo = d_lo * $signed({1'b0, frac_q});
  assign p_hi = d_hi * $signed({1'b0, frac_q});
  assign d_mix = 18'(hi_q) - 18'(lo_q);
  assign p_mix = d_mix * $signed({1'b0, w_q});
  assign mag = mix_q[16] ? 17'(-mix_q) : 17'(mix_q);
  assign q_mag = prod_q[RECIP_SHIFT+12:RECIP_SHIFT];
  assign q_out = neg_q ? 13'(-$signed(q_mag)) : $signed(q_mag);

  // Sequencer: next state and control.
  always_comb begin
    state_d = state_q;
    cmd_pop_o = 1'b0;
    mem_we = 1'b0;
    div_start = 1'b0;
    div_num = NW'(pitch_q) << (IW + OCT_FRAC_W);
    div_den = (rate_q == '0) ? DW'(1) : DW'(rate_q);
    out_push = 1'b0;
    rd_addr = {k_q, idx_q};
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.tick) begin
            div_start = 1'b1;
            state_d = ST_DIVW;
          end else begin
            mem_we = cmd_i.wr_ok;
          end
        end
      end
      ST_DIVW: state_d = ST_DIVI;
      ST_DIVI: begin
        if (div_done) begin
          state_d = ST_RA0;
        end
      end
      ST_RA0: begin
        rd_addr = {k_q, idx_q};
        state_d = ST_RB0;
      end
      ST_RB0: begin
        rd_addr = {k_q, IW'(idx_q + 1'b1)};
        state_d = ST_RA1;
      end
      ST_RA1: begin
        rd_addr = {kup_q, idx_q};
        state_d = ST_RB1;
      end
      ST_RB1: begin
        rd_addr = {kup_q, IW'(idx_q + 1'b1)};
        state_d = ST_CAP;
      end
      ST_CAP: state_d = ST_MLO;
      ST_MLO: state_d = ST_MHI;
      ST_MHI: state_d = ST_MIX;
      ST_MIX: state_d = ST_SCL;
      ST_SCL: state_d = ST_OUT;
      ST_OUT: begin
        if (!out_full) begin
          out_push = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= '0;
    end else begin
      state_q <= state_d;
      if (out_push) begin
        phase_q <= PW'(phase_q + inc_q);
      end
    end
  end

  // Datapath registers, loaded step by step.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        k_q <= k_c;
        kup_q <= (k_c == TOP) ? TOP : OW'(k_c + 1'b1);
        idx_q <= phase_q[PW-1:PHASE_FRAC_W];
        frac_q <= phase_q[PHASE_FRAC_W-1:0];
        y_q <= y_c;
      end
      ST_DIVW: w_q <= w_prod[RECIP_FIVE_SHIFT+11:RECIP_FIVE_SHIFT];
      ST_DIVI: if (div_done) inc_q <= div_quo[PW-1:0];
      ST_RB0: a0_q <= rdata_q;
      ST_RA1: b0_q <= rdata_q;
      ST_RB1: a1_q <= rdata_q;
      ST_CAP: b1_q <= rdata_q;
      ST_MLO: lo_q <= 17'(a0_q) + 17'(p_lo >>> PHASE_FRAC_W);
      ST_MHI: hi_q <= 17'(a1_q) + 17'(p_hi >>> PHASE_FRAC_W);
      ST_MIX: mix_q <= lo_q + 17'(p_mix >>> OCT_FRAC_W);
      ST_SCL: begin
        prod_q <= 33'(mag + 17'd5) * 33'(RECIP_TEN);
        neg_q <= mix_q[16];
      end
      default: begin
      end
    endcase
  end

  // Two-entry result queue so a stalled receiver does not block the next tick.
  assign out_full = (ocnt_q == 2'd2);
  assign empty_o = (ocnt_q == 2'd0);
  assign out_pop = pop_i && !empty_o;
  assign sample_out_o = res_q[orp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ocnt_q <= '0;
      owp_q <= 1'b0;
      orp_q <= 1'b0;
    end else begin
      if (out_push) begin
        owp_q <= ~owp_q;
      end
      if (out_pop) begin
        orp_q <= ~orp_q;
      end
      ocnt_q <= 2'(ocnt_q + {1'b0, out_push} - {1'b0, out_pop});
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_push) begin
      res_q[owp_q] <= q_out;
    end
  end

`ifndef SYNTHESIS
  a_ocnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ocnt_q <= 2'd2) else $error("result queue count out of range");
  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy || div_done) else $error("divider restarted while busy");
  a_push_after_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push |-> state_q == ST_OUT) else $error("result pushed outside output step");
  a_phase_moves_on_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_push |=> $stable(phase_q)) else $error("phase changed without a tick");
`endif
endmodule

[src/band_limited_wavetable_oscillator_unit.sv]
// Top level of the band-limited wavetable oscillator.
//
// Input channel: push/full. mode_i low writes entry_value_i into octave
// octave_select_i at entry_index_i (out-of-range writes are dropped); mode_i
// high is a tick that yields one sample. A two-entry command queue takes items
// while the back end works.
// Result channel: empty/pop. sample_out_o holds the oldest sample while empty
// is low; a two-entry result queue absorbs a stalled receiver, and the back
// end waits only when that queue is full.
// Configuration: cfg_valid_i/cfg_ready_o, always ready; index 0 is the pitch
// in sixteenths of a hertz, index 1 the sample rate. Write only while idle.
// Sequence: a write is stored straight from the idle state. A tick runs
// the bit-serial divider that derives the phase increment, then four
// table reads on the single read port and the interpolation steps.
// Reset clears the phase and the queues and sets the configuration registers
// to their defaults; table contents are undefined until written.
`timescale 1ns / 1ps
module band_limited_wavetable_oscillator_unit
  import blwo_pkg::*;
#(
  parameter int TABLE_LENGTH = TABLE_LENGTH_DEF,
  parameter int OCTAVE_COUNT = OCTAVE_COUNT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic                  mode_i,
  input  logic [3:0]            octave_select_i,
  input  logic [9:0]            entry_index_i,
  input  logic signed [15:0]    entry_value_i,
  output logic                  empty,
  input  logic                  pop,
  output logic signed [12:0]    sample_out_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);
  cmd_t cmd;
  logic cmd_valid, cmd_pop;

  assign cfg_ready_o = 1'b1;

  blwo_front #(.TABLE_LENGTH(TABLE_LENGTH), .OCTAVE_COUNT(OCTAVE_COUNT)) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .full_o          (full),
    .mode_i          (mode_i),
    .octave_select_i (octave_select_i),
    .entry_index_i   (entry_index_i),
    .entry_value_i   (entry_value_i),
    .cmd_valid_o     (cmd_valid),
    .cmd_o           (cmd),
    .cmd_pop_i       (cmd_pop)
  );

  blwo_back #(.TABLE_LENGTH(TABLE_LENGTH), .OCTAVE_COUNT(OCTAVE_COUNT)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd),
    .cmd_pop_o    (cmd_pop),
    .cfg_we_i     (cfg_valid_i & cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .empty_o      (empty),
    .pop_i        (pop),
    .sample_out_o (sample_out_o)
  );
endmodule
